FILE: rtl/core/rising_edge_interval_timestamper_defines.svh
// assertion macros used by the checker file
`ifndef RISING_EDGE_INTERVAL_TIMESTAMPER_DEFINES_SVH
`define RISING_EDGE_INTERVAL_TIMESTAMPER_DEFINES_SVH

// consequent checked in the same cycle
`define REI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define REI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rei_pkg.sv
package rei_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int TICK_W           = 32;
    localparam int CHAN_W           = 4;
    localparam int NODE_W           = 8;
    localparam int FRAME_W          = 10;
    localparam logic [FRAME_W-1:0] FRAME_BASE = 10'h180;

    // channel + interval + frame id, padded to whole bytes
    localparam int M_FIELDS_W = CHAN_W + TICK_W + FRAME_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic shift;    // move the scan token one cell on
        logic rise;     // this cell's channel rose in the current tick
    } t_cell_ctrl;

endpackage

FILE: rtl/core/rei_cell.sv
module rei_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rei_pkg::t_cell_ctrl           i_ctrl,
    input  logic                          i_tok,
    input  logic [rei_pkg::TICK_W-1:0]    i_tick,
    output logic                          o_tok,
    output logic                          o_hit,
    output logic [rei_pkg::TICK_W-1:0]    o_diff
);

    logic                          r_tok;
    logic [rei_pkg::TICK_W-1:0]    r_edge;
    logic [rei_pkg::TICK_W-1:0]    n_diff;

    assign o_tok = r_tok;
    assign o_hit = r_tok & i_ctrl.rise;

    always_comb begin
        if (i_tick > r_edge) begin
            n_diff = i_tick - r_edge;
        end else begin
            n_diff = r_edge - i_tick;
        end
    end

    // masked so the top level can or the cells together
    assign o_diff = o_hit ? n_diff : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_edge <= '0;
        end else begin
            if (i_ctrl.shift) begin
                r_tok <= i_tok;
            end
            // a hit only shifts once its word is loaded, so store the tick then
            if (i_ctrl.shift && o_hit) begin
                r_edge <= i_tick;
            end
        end
    end

endmodule

FILE: rtl/core/rising_edge_interval_timestamper.sv
// the tick and rising flags are registered on arrival, and the word for channel c is
// registered in the output register once the scan token reaches cell c; the token
//   walks the row of N cells (N = active channels, 16 by default) one cell per cycle,
//   holding while a word waits on a stalled output, and no new tick is taken until it leaves
// reset (synchronous, active low) clears the tick counter, previous sample,
//   all edge times, node id and the output valid flag
module rising_edge_interval_timestamper #(
    parameter int NUM_CHANNELS = rei_pkg::NUM_CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [rei_pkg::SAMPLE_BITS-1:0] i_s_axis_tdata,   // pin_sample
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // channel, interval_ticks, frame_id, zero pad
    output logic [rei_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                            o_m_axis_tlast,   // last_of_tick
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rei_pkg::NODE_W-1:0]      i_cfg_data        // node_id
);

    localparam int NCELL = (NUM_CHANNELS < rei_pkg::SAMPLE_BITS) ?
                           NUM_CHANNELS : rei_pkg::SAMPLE_BITS;

    logic [rei_pkg::TICK_W-1:0]      r_tick, n_tick;
    logic [rei_pkg::SAMPLE_BITS-1:0] r_prev;
    logic [NCELL-1:0]                r_rise, n_rise;
    logic [rei_pkg::NODE_W-1:0]      r_node;

    logic                            r_oval;
    logic [rei_pkg::CHAN_W-1:0]      r_ochan;
    logic [rei_pkg::TICK_W-1:0]      r_odiff;
    logic [rei_pkg::FRAME_W-1:0]     r_oframe;
    logic                            r_olast;

    logic [NCELL-1:0]                w_tok;
    logic [NCELL-1:0]                w_hit;
    logic [rei_pkg::TICK_W-1:0]      w_diff [NCELL];
    logic [NCELL-1:0]                w_tok_in;

    logic                            accept;
    logic                            busy;
    logic                            hit_any;
    logic                            out_free;
    logic                            emit;
    logic                            shift;
    logic [rei_pkg::TICK_W-1:0]      sel_diff;
    logic [rei_pkg::CHAN_W-1:0]      sel_chan;
    logic [NCELL-1:0]                rest;

    assign busy            = |w_tok;
    assign o_s_axis_tready = ~busy;
    assign o_cfg_ready     = 1'b1;
    assign accept          = i_s_axis_tvalid & o_s_axis_tready;
    assign hit_any         = |w_hit;
    assign out_free        = ~r_oval | i_m_axis_tready;
    assign emit            = hit_any & out_free;
    assign shift           = accept | (busy & (~hit_any | out_free));

    // token enters cell 0 on the tick's arrival
    always_comb begin
        w_tok_in = {w_tok[NCELL-1:0] << 1};
        w_tok_in[0] = accept;
    end

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            rei_pkg::t_cell_ctrl ctrl;
            assign ctrl.shift = shift;
            assign ctrl.rise  = r_rise[g];
            rei_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (ctrl),
                .i_tok   (w_tok_in[g]),
                .i_tick  (r_tick),
                .o_tok   (w_tok[g]),
                .o_hit   (w_hit[g]),
                .o_diff  (w_diff[g])
            );
        end
    endgenerate

    always_comb begin
        sel_diff = '0;
        sel_chan = '0;
        for (int i = 0; i < NCELL; i++) begin
            sel_diff = sel_diff | w_diff[i];
            if (w_hit[i]) begin
                sel_chan = sel_chan | rei_pkg::CHAN_W'(i);
            end
        end
    end

    assign rest = r_rise & ~w_hit;

    always_comb begin
        n_tick = r_tick;
        n_rise = r_rise;
        if (accept) begin
            n_tick = r_tick + rei_pkg::TICK_W'(1);
            n_rise = i_s_axis_tdata[NCELL-1:0] & ~r_prev[NCELL-1:0];
        end else if (emit) begin
            n_rise = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_prev <= '0;
            r_rise <= '0;
            r_node <= '0;
            r_oval <= 1'b0;
        end else begin
            r_tick <= n_tick;
            r_rise <= n_rise;
            if (accept) begin
                r_prev <= i_s_axis_tdata;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_node <= i_cfg_data;
            end
            if (emit) begin
                r_oval <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ochan  <= sel_chan;
            r_odiff  <= sel_diff;
            r_oframe <= rei_pkg::FRAME_BASE + {2'b00, r_node};
            r_olast  <= ~|rest;
        end
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {(rei_pkg::M_TDATA_W - rei_pkg::M_FIELDS_W)'(0),
                              r_oframe, r_odiff, r_ochan};

endmodule

FILE: rtl/core/rei_checker.sv
`include "rising_edge_interval_timestamper_defines.svh"

module rei_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [rei_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                          o_m_axis_tlast
);

    // a stalled output word holds
    `REI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "output word changed while stalled")

    // a taken tick starts a scan, so the input closes next cycle
    `REI_ASSERT_NEXT(a_scan_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input still open after a tick was taken")

    // frame id lies in its range and the pad bits are zero
    `REI_ASSERT_NOW(a_frame_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[45:36] >= 10'd384 && o_m_axis_tdata[45:36] <= 10'd639 && o_m_axis_tdata[47:46] == 2'b00, "frame id out of range")

endmodule

bind rising_edge_interval_timestamper rei_checker u_rei_checker (.*);

FILE: tb/rising_edge_interval_timestamper_tb.sv
`timescale 1ns / 1ps

module rising_edge_interval_timestamper_tb;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 24;      // scan of 16 cells plus output register
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASE_TICKS   = 80;
    localparam logic [rei_pkg::FRAME_W-1:0] FRAME_ID_BASE = 10'h180;

    // output word layout, lowest bit up
    localparam int CH_LSB    = 0;
    localparam int IVL_LSB   = rei_pkg::CHAN_W;
    localparam int FRAME_LSB = rei_pkg::CHAN_W + rei_pkg::TICK_W;

    typedef struct packed {
        logic [rei_pkg::CHAN_W-1:0]  channel;
        logic [rei_pkg::TICK_W-1:0]  interval;
        logic [rei_pkg::FRAME_W-1:0] frame_id;
        logic                        last_of_tick;
    } t_edge_report;

    logic                            i_clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_valid = 1'b0;
    logic [rei_pkg::SAMPLE_BITS-1:0] s_data = '0;
    logic                            m_ready = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [rei_pkg::NODE_W-1:0]      cfg_data = '0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [rei_pkg::M_TDATA_W-1:0]   o_m_axis_tdata;
    logic                            o_m_axis_tlast;
    logic                            o_cfg_ready;

    // predictor state
    logic [rei_pkg::TICK_W-1:0]      tick_now = '0;
    logic [rei_pkg::SAMPLE_BITS-1:0] prev_pins = '0;
    logic [rei_pkg::TICK_W-1:0]      edge_time [rei_pkg::SAMPLE_BITS];
    logic [rei_pkg::NODE_W-1:0]      node_id = '0;
    t_edge_report                    pending_reports [$];

    int failures = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    rising_edge_interval_timestamper dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < rei_pkg::SAMPLE_BITS; i++) edge_time[i] = '0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** rising_edge_interval_timestamper: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void report_failure(input string msg);
        failures++;
        if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_field(input string what,
                                        input logic [rei_pkg::TICK_W-1:0] want,
                                        input logic [rei_pkg::TICK_W-1:0] got);
        if (want !== got) begin
            report_failure($sformatf("%s expected %0d, got %0d", what, want, got));
        end
    endfunction

    // one tick: advance the counter, report every channel that rose, lowest first
    function automatic void predict_tick(input logic [rei_pkg::SAMPLE_BITS-1:0] pins);
        logic [rei_pkg::SAMPLE_BITS-1:0] rose;
        logic [rei_pkg::TICK_W-1:0]      stamp;
        t_edge_report                    rep;
        rose = pins & ~prev_pins;
        tick_now = tick_now + 1;
        for (int ch = 0; ch < rei_pkg::SAMPLE_BITS; ch++) begin
            if (rose[ch]) begin
                stamp = edge_time[ch];
                rep.channel = 4'(ch);
                rep.interval = (tick_now > stamp) ? tick_now - stamp : stamp - tick_now;
                rep.frame_id = FRAME_ID_BASE + {2'b00, node_id};
                rep.last_of_tick = ((rose >> (ch + 1)) == '0);
                edge_time[ch] = tick_now;
                pending_reports.push_back(rep);
            end
        end
        prev_pins = pins;
    endfunction

    always @(posedge i_clk) begin
        t_edge_report want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_reports.size() == 0) begin
                report_failure($sformatf("unexpected word ch %0d interval %0d",
                                         o_m_axis_tdata[CH_LSB +: rei_pkg::CHAN_W],
                                         o_m_axis_tdata[IVL_LSB +: rei_pkg::TICK_W]));
            end else begin
                want = pending_reports.pop_front();
                check_field("channel", want.channel,
                            o_m_axis_tdata[CH_LSB +: rei_pkg::CHAN_W]);
                check_field("interval_ticks", want.interval,
                            o_m_axis_tdata[IVL_LSB +: rei_pkg::TICK_W]);
                check_field("frame_id", want.frame_id,
                            o_m_axis_tdata[FRAME_LSB +: rei_pkg::FRAME_W]);
                check_field("last_of_tick", want.last_of_tick, o_m_axis_tlast);
            end
        end
    end

    // idle cycles are counted once the block is ready again, so the gap is seen
    task automatic send_tick(input logic [rei_pkg::SAMPLE_BITS-1:0] pins);
        if (send_idle_pct != 0) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
            while (!o_s_axis_tready || $urandom_range(0, 99) < send_idle_pct) begin
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= pins;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_tick(pins);
    endtask

    // hold off until every expected word is out and the scan has finished
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_node_id(input logic [rei_pkg::NODE_W-1:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        node_id = value;
    endtask

    function automatic logic [rei_pkg::SAMPLE_BITS-1:0] next_pins(
        input logic [rei_pkg::SAMPLE_BITS-1:0] cur);
        case ($urandom_range(0, 9))
            0, 1, 2: return rei_pkg::SAMPLE_BITS'($urandom);
            3:       return ~cur;
            4:       return cur ^ (16'h0001 << $urandom_range(0, rei_pkg::SAMPLE_BITS - 1));
            5:       return '0;
            6:       return '1;
            7:       return cur | rei_pkg::SAMPLE_BITS'($urandom);
            8:       return cur & rei_pkg::SAMPLE_BITS'($urandom);
            default: return cur;    // held pins keep intervals growing
        endcase
    endfunction

    // reset node id, first edges, all channels at once, held and alternating pins
    task automatic test_edge_basics();
        send_tick(16'h0000);
        send_tick(16'h0001);
        send_tick(16'h8000);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'hFFFF);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'hAAAA);
        send_tick(16'h5555);
        send_tick(16'hFFFF);
        send_tick(16'h0000);
        send_tick(16'h0001);
        wait_for_results();
    endtask

    task automatic test_node_id_range();
        logic [rei_pkg::NODE_W-1:0] ids [4];
        ids = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
        foreach (ids[i]) begin
            write_node_id(ids[i]);
            send_tick(16'h0000);
            send_tick(16'hFFFF);
        end
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input bit pause_midway);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_node_id(rei_pkg::NODE_W'($urandom_range(0, 255)));
        for (int n = 0; n < PHASE_TICKS; n++) begin
            if (pause_midway && n == PHASE_TICKS / 2) wait_for_results();
            send_tick(next_pins(prev_pins));
        end
        wait_for_results();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_basics();
        test_node_id_range();
        test_random_traffic(0, 0, 1'b0);
        test_random_traffic(77, 0, 1'b0);
        test_random_traffic(0, 77, 1'b1);
        test_random_traffic(21, 21, 1'b0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_node_id(8'hFF);
        for (int n = 0; n < 8; n++) send_tick(next_pins(prev_pins));
        wait_for_results();
        if (pending_reports.size() != 0) begin
            report_failure($sformatf("%0d words never arrived", pending_reports.size()));
        end
        if (failures == 0) begin
            $display("** rising_edge_interval_timestamper: PASSED **");
        end else begin
            $display("** rising_edge_interval_timestamper: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/rei_pkg.sv
rtl/core/rei_cell.sv
rtl/core/rising_edge_interval_timestamper.sv
rtl/core/rei_checker.sv
tb/rising_edge_interval_timestamper_tb.sv
